// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Operation and status codes, and the control word that is shared by the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PosWidth   = 4;
  localparam int unsigned CountWidth = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_HEAD   = 2'd3
  } spq_op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } spq_status_e;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // open a slot at the boundary, shift the tail right
    logic rem;  // close the slot at the boundary, shift the tail left
  } spq_ctrl_t;

endpackage

// File: hw/rtl/sorted_priority_queue_unit.sv
// Result: an accepted request's result is registered in the output register.
// Throughput: one request per cycle unless a held result waits on out_ready_i;
// the path is one compare per cell in parallel, a one-hot to index encode and the row shift.
// Reset: count and output valid clear at once; cell entries are not reset and
// are only read below the count.
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Row of compare-and-shift cells keeping signed values in ascending order,
// with insert, remove, find and get-head requests and a registered result.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  spq_pkg::spq_op_e                      operation_i,
  input  logic        [spq_pkg::ValueWidth-1:0] value_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output spq_pkg::spq_status_e                  status_o,
  output logic        [spq_pkg::ValueWidth-1:0] head_or_match_o,
  output logic        [spq_pkg::PosWidth-1:0]   position_o,
  output logic        [spq_pkg::CountWidth-1:0] count_o
);
  import spq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);

  logic [CW-1:0]         count_q, count_d;
  logic                  out_valid_q;
  spq_status_e           status_q, status_d;
  logic [ValueWidth-1:0] shown_q, shown_d;
  logic [IW-1:0]         pos_q, pos_d;

  logic [ValueWidth-1:0] entry [CAPACITY];
  logic [CAPACITY-1:0]   sel;
  logic [CAPACITY-1:0]   boundary;
  logic [CAPACITY-1:0]   hit;
  logic [CAPACITY-1:0]   occupied;
  logic [IW-1:0]         bound_idx;
  logic                  found;
  logic                  full;
  logic                  accept;
  spq_ctrl_t             ctrl;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign full       = count_q == CW'(CAPACITY);
  assign found      = |hit;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    assign occupied[g] = CW'(g) < count_q;
    spq_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .value_i       (value_i),
      .occupied_i    (occupied[g]),
      .sel_prev_i    ((g == 0) ? 1'b0 : sel[(g == 0) ? 0 : g - 1]),
      .left_entry_i  ((g == 0) ? value_i : entry[(g == 0) ? 0 : g - 1]),
      .right_entry_i (entry[(g == CAPACITY - 1) ? g : g + 1]),
      .entry_o       (entry[g]),
      .sel_o         (sel[g]),
      .boundary_o    (boundary[g]),
      .hit_o         (hit[g])
    );
  end

  // boundary is one-hot whenever a free cell exists or some entry is >= value
  always_comb begin
    bound_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      bound_idx = bound_idx | (boundary[i] ? IW'(i) : '0);
    end
  end

  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = ST_OK;
    shown_d  = '0;
    pos_d    = '0;
    case (operation_i)
      OP_INSERT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = accept;
          pos_d    = bound_idx;
          count_d  = count_q + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          ctrl.rem = accept;
          pos_d    = bound_idx;
          count_d  = count_q - CW'(1);
        end else begin
          status_d = ST_MISS;
        end
      end
      OP_FIND: begin
        if (found) begin
          pos_d   = bound_idx;
          shown_d = value_i;
        end else begin
          status_d = ST_MISS;
        end
      end
      OP_HEAD: begin
        if (count_q == '0) begin
          status_d = ST_MISS;
        end else begin
          shown_d = entry[0];
        end
      end
      default: begin
        status_d = ST_MISS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      shown_q  <= shown_d;
      pos_q    <= pos_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign head_or_match_o = shown_q;
  assign position_o      = PosWidth'(pos_q);
  // count only moves on accept, which needs the held result to be taken
  assign count_o         = CountWidth'(count_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("count above capacity");

  a_hit_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit))
    else $error("more than one first match");

  a_boundary_onehot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !full |-> $onehot(boundary))
    else $error("insert boundary not unique");

  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && operation_i == OP_INSERT && !full |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not grow count");

  a_full_status : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q == ST_FULL |-> full)
    else $error("full reported below capacity");

endmodule

// File: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry, compares it with the request value and takes the value or
// a neighbor's entry when the row shifts.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic                                  clk_i,
  input  spq_pkg::spq_ctrl_t                    ctrl_i,
  input  logic        [spq_pkg::ValueWidth-1:0] value_i,
  input  logic                                  occupied_i,
  input  logic                                  sel_prev_i,
  input  logic        [spq_pkg::ValueWidth-1:0] left_entry_i,
  input  logic        [spq_pkg::ValueWidth-1:0] right_entry_i,
  output logic        [spq_pkg::ValueWidth-1:0] entry_o,
  output logic                                  sel_o,
  output logic                                  boundary_o,
  output logic                                  hit_o
);
  import spq_pkg::*;

  logic [ValueWidth-1:0] entry_q, entry_d;
  logic                  ge;
  logic                  eq;

  assign ge = $signed(entry_q) >= $signed(value_i);
  assign eq = entry_q == value_i;

  // A free cell counts as greater, so sel is monotonic along the row.
  assign sel_o      = !occupied_i || ge;
  assign boundary_o = sel_o && !sel_prev_i;
  assign hit_o      = boundary_o && occupied_i && eq;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins && boundary_o) begin
      entry_d = value_i;
    end else if (ctrl_i.ins && sel_o) begin
      entry_d = left_entry_i;
    end else if (ctrl_i.rem && sel_o) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

// File: tb/sorted_priority_queue_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue unit testbench
// Drives insert, remove, find and get-head requests through the valid/ready
// input channel, keeps its own sorted store to predict every result and checks
// each result field against the oldest expected result (the table's for typed rows,
// else the prediction), with random idling on both channels.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit_tb;
  import spq_pkg::*;

  localparam int unsigned Capacity    = 16;
  localparam int unsigned RandomItems = 2000;
  localparam int unsigned SegmentLen  = 150;
  localparam int unsigned IdleLimit   = 2000;

  typedef struct packed {
    spq_status_e            status;
    logic [ValueWidth-1:0]  head_or_match;
    logic [PosWidth-1:0]    position;
    logic [CountWidth-1:0]  count;
  } queue_result_t;

  typedef struct packed {
    spq_op_e                op;
    logic [ValueWidth-1:0]  value;
    logic                   typed;
    queue_result_t          result;
  } request_row_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  spq_op_e                operation_i = OP_INSERT;
  logic [ValueWidth-1:0]  value_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  spq_status_e            status_o;
  logic [ValueWidth-1:0]  head_or_match_o;
  logic [PosWidth-1:0]    position_o;
  logic [CountWidth-1:0]  count_o;

  // Predicted queue contents, ascending signed order
  logic signed [ValueWidth-1:0] sorted_values [Capacity];
  int unsigned                  stored_count = 0;

  queue_result_t pending_results [$];
  request_row_t  request_table [$];
  int unsigned   error_count = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   ready_stall = 0;
  bit            burst_mode = 1'b0;

  sorted_priority_queue_unit #(
    .CAPACITY(Capacity)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .head_or_match_o(head_or_match_o),
    .position_o     (position_o),
    .count_o        (count_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Apply one request to the predicted store and return its result
  function automatic queue_result_t queue_predict(spq_op_e op, logic [ValueWidth-1:0] val);
    queue_result_t res;
    int unsigned   idx;
    int unsigned   hit;
    res = '{status: ST_OK, head_or_match: '0, position: '0, count: '0};
    hit = stored_count;
    if (op != OP_INSERT) begin
      for (idx = 0; idx < stored_count; idx++) begin
        if (sorted_values[idx] == val) begin
          hit = idx;
          break;
        end
      end
    end
    case (op)
      OP_INSERT: begin
        if (stored_count >= Capacity) begin
          res.status = ST_FULL;
        end else begin
          hit = stored_count;
          for (idx = 0; idx < stored_count; idx++) begin
            if (sorted_values[idx] >= $signed(val)) begin
              hit = idx;
              break;
            end
          end
          for (idx = stored_count; idx > hit; idx--) sorted_values[idx] = sorted_values[idx-1];
          sorted_values[hit] = val;
          stored_count++;
          res.position = hit[PosWidth-1:0];
        end
      end
      OP_REMOVE: begin
        if (hit >= stored_count) begin
          res.status = ST_MISS;
        end else begin
          for (idx = hit; idx + 1 < stored_count; idx++) sorted_values[idx] = sorted_values[idx+1];
          stored_count--;
          res.position = hit[PosWidth-1:0];
        end
      end
      OP_FIND: begin
        if (hit >= stored_count) begin
          res.status = ST_MISS;
        end else begin
          res.position      = hit[PosWidth-1:0];
          res.head_or_match = sorted_values[hit];
        end
      end
      default: begin
        if (stored_count == 0) res.status = ST_MISS;
        else res.head_or_match = sorted_values[0];
      end
    endcase
    res.count = stored_count[CountWidth-1:0];
    return res;
  endfunction

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [ValueWidth-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40 && stored_count > 0) return sorted_values[$urandom_range(0, stored_count - 1)];
    if (r < 60) return ValueWidth'($signed($urandom_range(0, 8)) - 4);
    if (r < 70) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'hFFFF_FFFF;
        default: return 32'h0000_0000;
      endcase
    end
    return $urandom();
  endfunction

  task automatic add_row(spq_op_e op, logic [ValueWidth-1:0] val, logic typed,
                         spq_status_e st, logic [ValueWidth-1:0] shown,
                         int unsigned pos, int unsigned cnt);
    request_row_t row;
    row.op                   = op;
    row.value                = val;
    row.typed                = typed;
    row.result.status        = st;
    row.result.head_or_match = shown;
    row.result.position      = pos[PosWidth-1:0];
    row.result.count         = cnt[CountWidth-1:0];
    request_table.push_back(row);
  endtask

  // Present one request, hold it until accepted, then record its result
  task automatic send_request(request_row_t row);
    int unsigned   gap;
    queue_result_t predicted;
    gap = pick_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= row.op;
    value_i     <= row.value;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = queue_predict(row.op, row.value);
    pending_results.push_back(row.typed ? row.result : predicted);
  endtask

  // Hold the sender until every outstanding result has been returned
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (ready_stall > 0) begin
      out_ready_i <= 1'b0;
      ready_stall--;
    end else begin
      out_ready_i <= 1'b1;
      ready_stall = pick_idle();
    end
  end

  always @(posedge clk_i) begin
    queue_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status %0d value %h position %0d count %0d",
                 $time, status_o, head_or_match_o, position_o, count_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          error_count++;
        end
        if (head_or_match_o !== want.head_or_match) begin
          $display("%0t: head_or_match expected %h actual %h",
                   $time, want.head_or_match, head_or_match_o);
          error_count++;
        end
        if (position_o !== want.position) begin
          $display("%0t: position expected %0d actual %0d", $time, want.position, position_o);
          error_count++;
        end
        if (count_o !== want.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want.count, count_o);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    request_row_t row;
    int unsigned  n;
    int unsigned  r;
    int unsigned  bias;
    int unsigned  ins_lim;
    int unsigned  rem_lim;

    // Empty queue, extremes, equal values, miss and full
    add_row(OP_HEAD,   32'h0000_0000, 1, ST_MISS, 32'h0, 0, 0);
    add_row(OP_FIND,   32'h0000_0005, 1, ST_MISS, 32'h0, 0, 0);
    add_row(OP_REMOVE, 32'h0000_0005, 1, ST_MISS, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h7FFF_FFFF, 1, ST_OK,   32'h0, 0, 1);
    add_row(OP_INSERT, 32'h8000_0000, 1, ST_OK,   32'h0, 0, 2);
    add_row(OP_INSERT, 32'h0000_0000, 1, ST_OK,   32'h0, 1, 3);
    add_row(OP_INSERT, 32'h0000_0000, 1, ST_OK,   32'h0, 1, 4);
    add_row(OP_FIND,   32'h0000_0000, 1, ST_OK,   32'h0, 1, 4);
    add_row(OP_FIND,   32'h7FFF_FFFF, 1, ST_OK,   32'h7FFF_FFFF, 3, 4);
    add_row(OP_HEAD,   32'hDEAD_BEEF, 1, ST_OK,   32'h8000_0000, 0, 4);
    add_row(OP_REMOVE, 32'h8000_0000, 1, ST_OK,   32'h0, 0, 3);
    add_row(OP_REMOVE, 32'h0000_3039, 1, ST_MISS, 32'h0, 0, 3);
    add_row(OP_INSERT, 32'hFFFF_FFFF, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h0000_0001, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'hAAAA_AAAA, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h5555_5555, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h7FFF_FFFF, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h8000_0000, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h0000_0000, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h0000_3039, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'hFFFF_0000, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h0000_FFFF, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h7FFF_FFFE, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h8000_0001, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h0000_0002, 0, ST_OK, 32'h0, 0, 0);
    add_row(OP_INSERT, 32'h0000_0005, 1, ST_FULL, 32'h0, 0, 16);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (request_table[i]) send_request(request_table[i]);
    drain_results();

    // Random part: segments that lean toward filling, emptying or neither
    bias    = 2;
    ins_lim = 35;
    rem_lim = 70;
    for (n = 0; n < RandomItems; n++) begin
      if (n % SegmentLen == 0) begin
        bias       = $urandom_range(0, 2);
        burst_mode = ($urandom_range(0, 3) == 0);
        ins_lim    = (bias == 0) ? 55 : (bias == 1) ? 15 : 35;
        rem_lim    = 70;
      end
      if (n == RandomItems / 2) drain_results();
      r = $urandom_range(0, 99);
      row.op     = (r < ins_lim) ? OP_INSERT : (r < rem_lim) ? OP_REMOVE :
                   (r < 88) ? OP_FIND : OP_HEAD;
      row.value  = pick_value();
      row.typed  = 1'b0;
      row.result = '0;
      send_request(row);
    end

    burst_mode = 1'b0;
    drain_results();
    repeat (4) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/spq_pkg.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue_unit.sv
tb/sorted_priority_queue_unit_tb.sv
